>>> rtl/rgbpwm_pkg.sv
// ----------------------------------------------------------------------------
// rgbpwm_pkg: shared types and constants for the RGB soft PWM colour drift
// Channel state record, issue beat record, configuration bundle, register
// indexes and per-channel reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpwm_pkg;

	// Widest supported channel count and the index width that covers it
	localparam int MaxCh = 4;
	localparam int ChW   = $clog2(MaxCh);

	// Step limit after halving or doubling
	localparam logic signed [7:0] STEP_CAP = 8'sh10;

	// Operation codes of an input beat
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	// Bit of random_byte that selects halving
	localparam int HALVE_BIT = 7;

	typedef logic [ChW-1:0] ch_idx_t;

	// Per-channel state held in the channel memory
	typedef struct packed {
		logic [7:0] phase;
		logic [7:0] duty;
		logic [7:0] step;
		logic [7:0] ovf;
		logic       pin;
	} ch_state_t;

	// One channel visit travelling through the read/modify/write pipe
	typedef struct packed {
		logic       valid;
		ch_idx_t    ch;
		logic       op;
		logic [7:0] rnd;
		logic       last;
	} issue_t;

	// Configuration registers
	typedef struct packed {
		logic [7:0]       counter_top;
		logic [7:0]       duty_limit;
		logic [2:0][7:0]  interval;
		logic [7:0]       debounce_length;
	} cfg_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_COUNTER_TOP     = 3'd0,
		REG_DUTY_LIMIT      = 3'd1,
		REG_INTERVAL_RED    = 3'd2,
		REG_INTERVAL_GREEN  = 3'd3,
		REG_INTERVAL_BLUE   = 3'd4,
		REG_DEBOUNCE_LENGTH = 3'd5
	} cfg_reg_t;

	// State of a channel entry that has not been written since reset
	function automatic ch_state_t ch_reset(ch_idx_t ch);
		ch_state_t s;
		s.ovf = 8'h00;
		s.pin = 1'b1;
		case (ch)
			2'd0: begin
				s.phase = 8'h00; s.duty = 8'h20; s.step = 8'hFF;
			end
			2'd1: begin
				s.phase = 8'h55; s.duty = 8'h10; s.step = 8'h01;
			end
			2'd2: begin
				s.phase = 8'hAA; s.duty = 8'h30; s.step = 8'hFF;
			end
			default: begin
				s.phase = 8'h00; s.duty = 8'h20; s.step = 8'h01;
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rgbpwm_seq.sv
// ----------------------------------------------------------------------------
// rgbpwm_seq: input sequencer
// Holds the accepted beat, walks its channels one per cycle (the last waits
// for output room), reads memory per channel, registers visit with read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpwm_seq
	import rgbpwm_pkg::*;
#(
	parameter int CHANNELS = 3
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       op,
	input  wire logic [7:0] random_byte,
	input  wire logic       last_ok,
	output issue_t          iss,
	output issue_t          iss_s1
);

	localparam ch_idx_t LastCh = ch_idx_t'(CHANNELS - 1);

	logic       busy_q;
	logic       op_q;
	logic [7:0] rnd_q;
	ch_idx_t    ch_q;
	logic       is_last;
	logic       go;
	logic       accept;

	// Issue decision: the final channel waits for room at the output
	assign is_last  = (ch_q == LastCh);
	assign go       = busy_q && (!is_last || last_ok);
	assign in_stall = busy_q && !(go && is_last);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		iss.valid = go;
		iss.ch    = ch_q;
		iss.op    = op_q;
		iss.rnd   = rnd_q;
		iss.last  = is_last;
	end

	// Control and visit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
			iss_s1 <= '0;
		end else begin
			iss_s1.valid <= go;
			if (go) begin
				iss_s1.ch   <= ch_q;
				iss_s1.op   <= op_q;
				iss_s1.rnd  <= rnd_q;
				iss_s1.last <= is_last;
			end
			if (accept) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (go) begin
				if (is_last)
					busy_q <= 1'b0;
				else
					ch_q <= ch_q + 2'd1;
			end
		end
	end

	// Beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			rnd_q <= random_byte;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rgbpwm_chan_mem.sv
// ----------------------------------------------------------------------------
// rgbpwm_chan_mem: channel state memory
// One write and one registered read per cycle. Entries not yet written read
// as their reset state; a read of the entry being written picks up the new
// data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpwm_chan_mem
	import rgbpwm_pkg::*;
#(
	parameter int CHANNELS = 3
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rd_en,
	input  wire ch_idx_t   rd_ch,
	input  wire logic      wr_en,
	input  wire ch_idx_t   wr_ch,
	input  wire ch_state_t wr_data,
	output ch_state_t      rd_data
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	ch_state_t           mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	ch_state_t           mem_s1;
	ch_state_t           fwd_data_s1;
	logic                fwd_s1;
	logic                hit_s1;
	ch_idx_t             rch_s1;

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_ch[CW-1:0]] <= wr_data;
		if (rd_en) begin
			mem_s1      <= mem[rd_ch[CW-1:0]];
			fwd_data_s1 <= wr_data;
			rch_s1      <= rd_ch;
		end
	end

	// Written marks and read qualifiers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			fwd_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_ch[CW-1:0]] <= 1'b1;
			if (rd_en) begin
				fwd_s1 <= wr_en && (wr_ch == rd_ch);
				hit_s1 <= vld_q[rd_ch[CW-1:0]];
			end
		end
	end

	// Read data selection
	always_comb begin
		if (fwd_s1)
			rd_data = fwd_data_s1;
		else if (hit_s1)
			rd_data = mem_s1;
		else
			rd_data = ch_reset(rch_s1);
	end

endmodule

`default_nettype wire

>>> rtl/rgbpwm_chan_upd.sv
// ----------------------------------------------------------------------------
// rgbpwm_chan_upd: channel update
// Advances one channel on a tick (phase, pin, drift hook) or applies a colour
// jump on a press.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpwm_chan_upd
	import rgbpwm_pkg::*;
#(
	parameter int CHANNELS = 3
) (
	input  wire issue_t    vis,
	input  wire ch_state_t cur,
	input  wire cfg_t      cfg,
	input  wire logic      btn_en,
	output ch_state_t      nxt,
	output logic           wrap0
);

	logic [7:0]        intv;
	logic [7:0]        ph_inc;
	logic [7:0]        ph;
	logic [7:0]        ovf_inc;
	logic signed [9:0] sum;
	logic signed [8:0] s9;
	logic signed [8:0] half9;
	logic signed [7:0] cand;
	logic [7:0]        new_step;
	logic [1:0]        pick;
	logic              hit;
	logic              wrap;

	// Drift interval of this channel; a fourth channel never drifts
	always_comb begin
		case (vis.ch)
			2'd0:    intv = cfg.interval[0];
			2'd1:    intv = cfg.interval[1];
			2'd2:    intv = cfg.interval[2];
			default: intv = 8'h00;
		endcase
	end

	// Step rescale for a jump: halve toward zero or double, then cap
	always_comb begin
		s9    = {cur.step[7], cur.step};
		half9 = (s9 + {8'h00, cur.step[7]}) >>> 1;
		if (vis.rnd[HALVE_BIT])
			cand = half9[7:0];
		else
			cand = {cur.step[6:0], 1'b0};
		if (cur.step == 8'h00)
			new_step = 8'h01;
		else if (cand > STEP_CAP)
			new_step = STEP_CAP;
		else
			new_step = cand;
	end

	// Channel pick, out of range falls back to channel 0
	always_comb begin
		pick = vis.rnd[1:0];
		if (int'(pick) >= CHANNELS)
			pick = 2'd0;
		hit = (vis.ch == pick);
	end

	// Main update
	always_comb begin
		nxt     = cur;
		wrap    = 1'b0;
		ph_inc  = cur.phase + 8'd1;
		ph      = (ph_inc > cfg.counter_top) ? 8'h00 : ph_inc;
		ovf_inc = cur.ovf + 8'd1;
		sum     = $signed({2'b00, cur.duty}) + $signed({{2{cur.step[7]}}, cur.step});
		if (vis.op == OP_PRESS) begin
			if (btn_en) begin
				nxt.duty = 8'h01;
				nxt.pin  = 1'b1;
				if (hit)
					nxt.step = new_step;
			end
		end else begin
			nxt.phase = ph;
			if (ph == cur.duty) begin
				nxt.pin = 1'b1;
			end else if (ph == 8'h00) begin
				nxt.pin = 1'b0;
				wrap    = 1'b1;
				if (intv != 8'h00) begin
					if (ovf_inc < intv) begin
						nxt.ovf = ovf_inc;
					end else begin
						nxt.ovf = 8'h00;
						if (sum <= 10'sd0) begin
							nxt.duty = 8'h01;
							nxt.step = 8'h00 - cur.step;
						end else if (sum > $signed({2'b00, cfg.duty_limit})) begin
							nxt.duty = cfg.duty_limit;
							nxt.step = 8'h00 - cur.step;
						end else begin
							nxt.duty = sum[7:0];
						end
					end
				end
			end
		end
	end

	assign wrap0 = wrap && (vis.ch == 2'd0);

endmodule

`default_nettype wire

>>> rtl/rgb_soft_pwm_colour_drift.sv
// ----------------------------------------------------------------------------
// rgb_soft_pwm_colour_drift: three-channel inverted soft PWM with colour drift
//
// Input channel (in_valid/in_stall): op 0 is a timer tick, op 1 a colour
// button press carrying random_byte. Each input beat yields exactly one
// output beat (out_valid/out_stall) with all pin levels, duty values and
// button_ready after that beat. Configuration writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data) are always taken; the user must make them while the
// block idles, as the block itself does not enforce this. Channel state
// lives in a small memory; each beat visits the channels one per cycle
// (read, update, write back), the final visit waiting for room at the
// output. The single memory port sets the sustained rate. The next beat is
// taken while a result waits. When the receiver stalls, the final channel
// visit of the following beat is held until the output register frees.
// Reset restores configuration defaults, channel start values, and enables
// the button; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_soft_pwm_colour_drift
	import rgbpwm_pkg::*;
#(
	parameter int CHANNELS = 3
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       op,
	input  wire logic [7:0] random_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            pin_red,
	output logic            pin_green,
	output logic            pin_blue,
	output logic [7:0]      duty_red,
	output logic [7:0]      duty_green,
	output logic [7:0]      duty_blue,
	output logic            button_ready,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	cfg_t       cfg_q;
	logic [7:0] deb_q;
	logic       btn_en_q;
	logic       btn_en_d;
	logic       press_en_q;
	logic       btn_eff;
	logic       last_ok;
	issue_t     iss;
	issue_t     iss_s1;
	ch_state_t  cur;
	ch_state_t  nxt;
	logic       wrap0;
	logic       ch0_s1;
	logic [2:0] build_pin_q;
	logic [2:0][7:0] build_duty_q;
	logic       out_valid_q;
	logic [2:0] out_pin_q;
	logic [2:0][7:0] out_duty_q;
	logic       out_btn_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counter_top     <= 8'hFF;
			cfg_q.duty_limit      <= 8'hFF;
			cfg_q.interval[0]     <= 8'd2;
			cfg_q.interval[1]     <= 8'd3;
			cfg_q.interval[2]     <= 8'd1;
			cfg_q.debounce_length <= 8'd32;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COUNTER_TOP:     cfg_q.counter_top     <= cfg_data;
				REG_DUTY_LIMIT:      cfg_q.duty_limit      <= cfg_data;
				REG_INTERVAL_RED:    cfg_q.interval[0]     <= cfg_data;
				REG_INTERVAL_GREEN:  cfg_q.interval[1]     <= cfg_data;
				REG_INTERVAL_BLUE:   cfg_q.interval[2]     <= cfg_data;
				REG_DEBOUNCE_LENGTH: cfg_q.debounce_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// Final visit goes ahead only if the output register is free next cycle
	assign last_ok = !(iss_s1.valid && iss_s1.last) && (!out_valid_q || !out_stall);

	rgbpwm_seq #(
		.CHANNELS(CHANNELS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.random_byte(random_byte),
		.last_ok    (last_ok),
		.iss        (iss),
		.iss_s1     (iss_s1)
	);

	rgbpwm_chan_mem #(
		.CHANNELS(CHANNELS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (iss.valid),
		.rd_ch  (iss.ch),
		.wr_en  (iss_s1.valid),
		.wr_ch  (iss_s1.ch),
		.wr_data(nxt),
		.rd_data(cur)
	);

	// Button state seen by this visit: live on channel 0, latched for the rest
	assign ch0_s1  = (iss_s1.ch == 2'd0);
	assign btn_eff = ch0_s1 ? btn_en_q : press_en_q;

	rgbpwm_chan_upd #(
		.CHANNELS(CHANNELS)
	) u_upd (
		.vis   (iss_s1),
		.cur   (cur),
		.cfg   (cfg_q),
		.btn_en(btn_eff),
		.nxt   (nxt),
		.wrap0 (wrap0)
	);

	// Button enable after this visit
	always_comb begin
		btn_en_d = btn_en_q;
		if (iss_s1.valid && ch0_s1) begin
			if (iss_s1.op == OP_PRESS) begin
				if (btn_en_q)
					btn_en_d = 1'b0;
			end else if (wrap0 && deb_q == 8'd1) begin
				btn_en_d = 1'b1;
			end
		end
	end

	// Debounce counter and button enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q      <= 8'h00;
			btn_en_q   <= 1'b1;
			press_en_q <= 1'b0;
		end else begin
			btn_en_q <= btn_en_d;
			if (iss_s1.valid && ch0_s1) begin
				press_en_q <= btn_en_q;
				if (iss_s1.op == OP_PRESS) begin
					if (btn_en_q)
						deb_q <= cfg_q.debounce_length;
				end else if (wrap0 && deb_q != 8'h00) begin
					deb_q <= deb_q - 8'd1;
				end
			end
		end
	end

	// Collect channel results of the current beat
	always_ff @(posedge clk) begin
		if (iss_s1.valid) begin
			for (int i = 0; i < 3; i++) begin
				if (int'(iss_s1.ch) == i) begin
					build_pin_q[i]  <= nxt.pin;
					build_duty_q[i] <= nxt.duty;
				end
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (iss_s1.valid && iss_s1.last) begin
			out_btn_q <= btn_en_d;
			for (int i = 0; i < 3; i++) begin
				if (i >= CHANNELS) begin
					out_pin_q[i]  <= 1'b1;
					out_duty_q[i] <= 8'h00;
				end else if (int'(iss_s1.ch) == i) begin
					out_pin_q[i]  <= nxt.pin;
					out_duty_q[i] <= nxt.duty;
				end else begin
					out_pin_q[i]  <= build_pin_q[i];
					out_duty_q[i] <= build_duty_q[i];
				end
			end
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (iss_s1.valid && iss_s1.last)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid    = out_valid_q;
	assign pin_red      = out_pin_q[0];
	assign pin_green    = out_pin_q[1];
	assign pin_blue     = out_pin_q[2];
	assign duty_red     = out_duty_q[0];
	assign duty_green   = out_duty_q[1];
	assign duty_blue    = out_duty_q[2];
	assign button_ready = out_btn_q;

endmodule

`default_nettype wire

>>> verif/rgb_soft_pwm_colour_drift_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_soft_pwm_colour_drift_check: scoreboard for the RGB soft PWM block
// Tracks configuration writes, updates its own copy of the three channels on
// every accepted input beat and queues the LED frame that beat should give.
// Each output beat is compared field by field against the oldest frame.
// ----------------------------------------------------------------------------
module rgb_soft_pwm_colour_drift_check
	import rgbpwm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic       op,
	input  wire logic [7:0] random_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       pin_red,
	input  wire logic       pin_green,
	input  wire logic       pin_blue,
	input  wire logic [7:0] duty_red,
	input  wire logic [7:0] duty_green,
	input  wire logic [7:0] duty_blue,
	input  wire logic       button_ready,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output int              mismatches,
	output int              frames_pending
);

	localparam int NUM_CH = 3;

	// Everything one output beat shows
	typedef struct packed {
		logic       pin_r;
		logic       pin_g;
		logic       pin_b;
		logic [7:0] duty_r;
		logic [7:0] duty_g;
		logic [7:0] duty_b;
		logic       ready;
	} led_frame_t;

	// Configuration copy
	logic [7:0] wrap_top;
	logic [7:0] duty_ceiling;
	logic [7:0] lockout_len;
	logic [7:0] drift_every [NUM_CH];

	// Channel and button state copy
	logic [7:0] phase [NUM_CH];
	logic [7:0] duty [NUM_CH];
	logic [7:0] step [NUM_CH];
	logic [7:0] wraps [NUM_CH];
	logic       pin [NUM_CH];
	logic [7:0] lockout_left;
	logic       button_on;

	led_frame_t frames_due [$];

	task automatic report(input string what, input int got, input int want);
		if (got != want) begin
			$display("ERROR %0t: %s is %0d, expected %0d", $time, what, got, want);
			mismatches++;
		end
	endtask

	// Overflow hook: every drift_every wraps, move the duty by the step
	task automatic drift_duty(input int ch);
		int nxt;
		int ceil_v;
		int s;
		if (drift_every[ch] == 8'd0)
			return;
		wraps[ch] = wraps[ch] + 8'd1;
		if (wraps[ch] < drift_every[ch])
			return;
		wraps[ch] = 8'd0;
		s = $signed(step[ch]);
		ceil_v = duty_ceiling;
		nxt = int'(duty[ch]) + s;
		if (nxt <= 0) begin
			nxt = 1;
			step[ch] = -step[ch];
		end else if (nxt > ceil_v) begin
			nxt = ceil_v;
			step[ch] = -step[ch];
		end
		duty[ch] = nxt[7:0];
	endtask

	task automatic timer_tick();
		logic red_wrapped;
		red_wrapped = 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			phase[i] = phase[i] + 8'd1;
			if (phase[i] > wrap_top)
				phase[i] = 8'd0;
			if (phase[i] == duty[i]) begin
				pin[i] = 1'b1;
			end else if (phase[i] == 8'd0) begin
				pin[i] = 1'b0;
				drift_duty(i);
				if (i == 0)
					red_wrapped = 1'b1;
			end
		end
		// Debounce counts red overflows; zero never expires
		if (red_wrapped && lockout_left != 8'd0) begin
			lockout_left = lockout_left - 8'd1;
			if (lockout_left == 8'd0)
				button_on = 1'b1;
		end
	endtask

	task automatic button_press(input logic [7:0] rnd);
		int pick;
		int s;
		logic [7:0] doubled;
		pick = int'(rnd[1:0]);
		if (!button_on)
			return;
		if (pick >= NUM_CH)
			pick = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			duty[i] = 8'd1;
			pin[i]  = 1'b1;
			if (i == pick) begin
				if (step[i] == 8'd0) begin
					step[i] = 8'd1;
				end else begin
					// Halve rounds toward zero; double wraps in 8 bits
					if (rnd[HALVE_BIT]) begin
						s = $signed(step[i]);
						s = s / 2;
					end else begin
						doubled = step[i] << 1;
						s = $signed(doubled);
					end
					if (s > int'(STEP_CAP))
						s = STEP_CAP;
					step[i] = s[7:0];
				end
			end
		end
		button_on    = 1'b0;
		lockout_left = lockout_len;
	endtask

	// Sample both channels and the register port on each edge
	always @(posedge clk or negedge arst_n) begin : watch
		led_frame_t want;
		led_frame_t next;
		if (!arst_n) begin
			wrap_top       = 8'd255;
			duty_ceiling   = 8'd255;
			drift_every[0] = 8'd2;
			drift_every[1] = 8'd3;
			drift_every[2] = 8'd1;
			lockout_len    = 8'd32;
			phase = '{8'h00, 8'h55, 8'hAA};
			duty  = '{8'h20, 8'h10, 8'h30};
			step  = '{8'hFF, 8'h01, 8'hFF};
			wraps = '{8'h00, 8'h00, 8'h00};
			pin   = '{1'b1, 1'b1, 1'b1};
			lockout_left = 8'd0;
			button_on    = 1'b1;
			frames_due.delete();
			mismatches = 0;
			frames_pending <= 0;
		end else begin
			// Result beat against the oldest frame
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$display("ERROR %0t: result beat with nothing outstanding", $time);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					report("pin_red", pin_red, want.pin_r);
					report("pin_green", pin_green, want.pin_g);
					report("pin_blue", pin_blue, want.pin_b);
					report("duty_red", duty_red, want.duty_r);
					report("duty_green", duty_green, want.duty_g);
					report("duty_blue", duty_blue, want.duty_b);
					report("button_ready", button_ready, want.ready);
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_COUNTER_TOP:     wrap_top       = cfg_data;
					REG_DUTY_LIMIT:      duty_ceiling   = cfg_data;
					REG_INTERVAL_RED:    drift_every[0] = cfg_data;
					REG_INTERVAL_GREEN:  drift_every[1] = cfg_data;
					REG_INTERVAL_BLUE:   drift_every[2] = cfg_data;
					REG_DEBOUNCE_LENGTH: lockout_len    = cfg_data;
					default: ;
				endcase
			end

			// Input beat: advance the copy and queue its frame
			if (in_valid && !in_stall) begin
				if (op == OP_PRESS)
					button_press(random_byte);
				else
					timer_tick();
				next.pin_r  = pin[0];
				next.pin_g  = pin[1];
				next.pin_b  = pin[2];
				next.duty_r = duty[0];
				next.duty_g = duty[1];
				next.duty_b = duty[2];
				next.ready  = button_on;
				frames_due.push_back(next);
			end
			frames_pending <= frames_due.size();
		end
	end

endmodule

>>> verif/rgb_soft_pwm_colour_drift_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_soft_pwm_colour_drift_test: top level of the RGB soft PWM testbench
// Drives ticks and colour presses in bursts through several register
// settings, stalls the result side on varying patterns and reports the
// verdict from the scoreboard's mismatch and pending frame counts.
// ----------------------------------------------------------------------------
module rgb_soft_pwm_colour_drift_test;
	import rgbpwm_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_style_t;

	localparam int HOLD_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       op = OP_TICK;
	logic [7:0] random_byte = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       pin_red;
	logic       pin_green;
	logic       pin_blue;
	logic [7:0] duty_red;
	logic [7:0] duty_green;
	logic [7:0] duty_blue;
	logic       button_ready;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = REG_COUNTER_TOP;
	logic [7:0] cfg_data = 8'd0;

	int mismatches;
	int frames_pending;

	stall_style_t stall_style = STALL_NONE;
	int           hold_req = 0;
	int           hold_seen;
	int           hold_left;
	int           stall_phase;

	rgb_soft_pwm_colour_drift u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.random_byte  (random_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pin_red      (pin_red),
		.pin_green    (pin_green),
		.pin_blue     (pin_blue),
		.duty_red     (duty_red),
		.duty_green   (duty_green),
		.duty_blue    (duty_blue),
		.button_ready (button_ready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rgb_soft_pwm_colour_drift_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.random_byte    (random_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pin_red        (pin_red),
		.pin_green      (pin_green),
		.pin_blue       (pin_blue),
		.duty_red       (duty_red),
		.duty_green     (duty_green),
		.duty_blue      (duty_blue),
		.button_ready   (button_ready),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.frames_pending (frames_pending)
	);

	always #6 clk = ~clk;

	// Result-side stall: long hold on request, otherwise the phase's pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			hold_seen   <= 0;
			hold_left   <= 0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 7;
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				case (stall_style)
					STALL_SPARSE:   out_stall <= ($urandom_range(0, 99) < 30);
					STALL_PERIODIC: out_stall <= (stall_phase < 3);
					STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 70);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Offer one beat and hold it until taken
	task automatic send_beat(input logic o, input logic [7:0] b);
		in_valid    <= 1'b1;
		op          <= o;
		random_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and wait for every frame to come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t r, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [7:0] top, input logic [7:0] limit,
		input logic [7:0] ir, input logic [7:0] ig, input logic [7:0] ib,
		input logic [7:0] deb);
		put_reg(REG_COUNTER_TOP, top);
		put_reg(REG_DUTY_LIMIT, limit);
		put_reg(REG_INTERVAL_RED, ir);
		put_reg(REG_INTERVAL_GREEN, ig);
		put_reg(REG_INTERVAL_BLUE, ib);
		put_reg(REG_DEBOUNCE_LENGTH, deb);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random beats in bursts; optional long result hold and mid-way drain
	task automatic run_phase(input int items, input int press_pct, input int gap_max,
		input stall_style_t style, input bit long_hold, input bit mid_drain);
		int burst;
		int gap;
		logic o;
		stall_style <= style;
		if (long_hold)
			hold_req <= hold_req + 1;
		burst = $urandom_range(1, 20);
		for (int k = 0; k < items; k++) begin
			o = ($urandom_range(0, 99) < press_pct) ? OP_PRESS : OP_TICK;
			send_beat(o, 8'($urandom_range(0, 255)));
			if (mid_drain && k == items / 2) begin
				settle();
			end else begin
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(1, 20);
					gap = $urandom_range(0, gap_max);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end
		settle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'hFF);
		settle();

		// Every tick overflows, one-wrap debounce: walk the press cases
		program_regs(8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1);
		send_beat(OP_PRESS, 8'h00);   // red step doubles
		send_beat(OP_PRESS, 8'h81);   // ignored while debouncing
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PRESS, 8'h81);   // green +1 halves to zero
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PRESS, 8'h01);   // zero step becomes one
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PRESS, 8'h82);   // blue +1 halves to zero
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PRESS, 8'h03);   // pick 3 falls back to red
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PRESS, 8'hFF);   // pick 3, halving
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PRESS, 8'h02);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h7F);
		send_beat(OP_TICK, 8'h80);
		settle();

		program_regs(8'd7, 8'd20, 8'd1, 8'd2, 8'd1, 8'd2);
		run_phase(150, 30, 6, STALL_SPARSE, 1'b1, 1'b0);

		program_regs(8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd1);
		run_phase(80, 35, 0, STALL_NONE, 1'b0, 1'b1);

		program_regs(8'd255, 8'd0, 8'd1, 8'd1, 8'd1, 8'd255);
		run_phase(70, 20, 3, STALL_PERIODIC, 1'b0, 1'b0);

		repeat (4) begin
			program_regs(8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
				8'($urandom_range(0, 4)), 8'($urandom_range(1, 4)));
			run_phase(70, 30, $urandom_range(0, 5),
				stall_style_t'($urandom_range(0, 3)), 1'b0, 1'b0);
		end

		// Zero debounce locks the button out for the rest of the run
		program_regs(8'd5, 8'd40, 8'd3, 8'd1, 8'd2, 8'd0);
		run_phase(50, 30, 4, STALL_HEAVY, 1'b0, 1'b0);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && frames_pending == 0)
			$display("rgb_soft_pwm_colour_drift: match");
		else
			$display("rgb_soft_pwm_colour_drift: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("rgb_soft_pwm_colour_drift: mismatch");
		$finish;
	end

endmodule
